### hdl/fet_pkg.sv
// Shared types, constants and sizes for the flow event tracker.
package fet_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FLOW_ID_BITS  = 16;

    localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

    localparam logic [15:0] ID_MASK =
        (FLOW_ID_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << FLOW_ID_BITS) - 32'd1);

    localparam logic [2:0] CODE_SEND = 3'd0;
    localparam logic [2:0] CODE_RECV = 3'd3;
    localparam logic [2:0] CODE_DROP = 3'd4;

    localparam logic [8:0]         CNT9_MAX  = 9'h1FF;
    localparam logic [31:0]        CNT32_MAX = 32'hFFFF_FFFF;
    localparam logic signed [15:0] PEND_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] PEND_MIN  = 16'sh8000;

    typedef struct packed {
        logic [15:0]        flow;
        logic signed [15:0] pending;
        logic [31:0]        sent;
        logic [31:0]        lost;
        logic [31:0]        start;
        logic [31:0]        last;
    } fet_rec_t;

    localparam int REC_BITS = $bits(fet_rec_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } fet_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic take;
        logic update;
    } fet_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
    } fet_status_t;

endpackage

### hdl/flow_event_tracker_unit.sv
// Flow event tracker top level: controller, datapath and interface checks.
// Sequence: an event is loaded, the table is scanned up to the matching entry
//   or to the last stored one, the record is updated, then done is raised.
// Throughput: a new event is taken only once the last is through; the scan reads
//   one table entry per cycle from the single read port of the flow table RAM.
// Reset: clears the flow, active and fill counts and the controller; the
//   table starts empty by its fill count, with no clearing pass.
// Results appear for one cycle on done; the receiver cannot stall them.
module flow_event_tracker_unit import fet_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        flow_id,
    input  logic [2:0]         command,
    input  logic [31:0]        timestamp,
    output logic               done,
    output logic               new_flow,
    output logic               table_full,
    output logic [8:0]         flow_total,
    output logic [8:0]         active_total,
    output logic signed [15:0] in_flight,
    output logic [31:0]        sent_count,
    output logic [31:0]        lost_count,
    output logic [31:0]        first_time,
    output logic [31:0]        latest_time
);

    fet_cmd_t    cmd;
    fet_status_t status;

    // Sequence each transfer: load the event, scan the table, apply the update.
    fet_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Hold the table, walk it one entry a cycle, and register each result.
    fet_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .flow_id      (flow_id),
        .command      (command),
        .timestamp    (timestamp),
        .done         (done),
        .new_flow     (new_flow),
        .table_full   (table_full),
        .flow_total   (flow_total),
        .active_total (active_total),
        .in_flight    (in_flight),
        .sent_count   (sent_count),
        .lost_count   (lost_count),
        .first_time   (first_time),
        .latest_time  (latest_time)
    );

`ifndef SYNTHESIS
    // An accepted transfer keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an event");

    // A result is shown only once the block is ready for the next transfer.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Each result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A new entry and a full table exclude each other.
    a_new_or_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(new_flow && table_full))
        else $error("new flow and table full reported together");
`endif

endmodule

### hdl/fet_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/fet_ctrl.sv
// Controller state machine: sequence load, table scan and update per event.
module fet_ctrl import fet_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  fet_status_t status,
    output fet_cmd_t    cmd,
    output logic        busy
);

    fet_state_t state_reg;
    fet_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.miss)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/fet_datapath.sv
// Datapath: flow table RAM, scan pointer, record update and result registers.
module fet_datapath import fet_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  fet_cmd_t           cmd,
    output fet_status_t        status,
    input  logic [15:0]        flow_id,
    input  logic [2:0]         command,
    input  logic [31:0]        timestamp,
    output logic               done,
    output logic               new_flow,
    output logic               table_full,
    output logic [8:0]         flow_total,
    output logic [8:0]         active_total,
    output logic signed [15:0] in_flight,
    output logic [31:0]        sent_count,
    output logic [31:0]        lost_count,
    output logic [31:0]        first_time,
    output logic [31:0]        latest_time
);

    // control state
    logic [CNT_BITS-1:0] fill_reg, fill_next;
    logic [CNT_BITS-1:0] scan_idx_reg;
    logic                pend_reg;
    logic [8:0]          seen_reg, seen_next;
    logic [8:0]          active_reg, active_next;
    logic                done_reg;

    // payload
    logic [15:0]         id_reg;
    logic [2:0]          code_reg;
    logic [31:0]         ts_reg;
    logic [IDX_BITS-1:0] cmp_idx_reg;
    logic [IDX_BITS-1:0] entry_reg;
    fet_rec_t            rec_reg;
    fet_rec_t            rec_next;
    logic                fresh_reg;
    logic                full_reg;

    logic                new_flow_reg;
    logic                table_full_reg;
    logic [8:0]          flow_total_reg;
    logic [8:0]          active_total_reg;
    fet_rec_t            out_rec_reg;

    fet_rec_t            rd_rec;
    logic [REC_BITS-1:0] rd_data;
    logic                more;
    logic                issue;
    logic                hit;
    logic                has_room;
    logic                wr_en;

    assign rd_rec   = fet_rec_t'(rd_data);
    assign more     = (scan_idx_reg < fill_reg);
    assign hit      = pend_reg && (rd_rec.flow == id_reg);
    assign issue    = cmd.scan && more && !hit;
    assign has_room = (fill_reg < CNT_BITS'(TABLE_ENTRIES));

    // Miss as soon as the last stored entry has been compared without a match.
    assign status.hit  = hit;
    assign status.miss = !more && !hit;

    assign wr_en = cmd.update && !full_reg;

    fet_ram #(
        .WIDTH (REC_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (entry_reg),
        .wr_data (rec_next),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[IDX_BITS-1:0]),
        .rd_data (rd_data)
    );

    // Apply the event to the taken record and to the global counts.
    always_comb
    begin
        logic signed [15:0] pend_dn;
        pend_dn     = rec_reg.pending - 16'sd1;
        rec_next    = rec_reg;
        fill_next   = fill_reg;
        seen_next   = seen_reg;
        active_next = active_reg;
        if (!full_reg)
        begin
            if (fresh_reg)
            begin
                fill_next = fill_reg + CNT_BITS'(1);
                if (seen_reg != CNT9_MAX)
                begin
                    seen_next = seen_reg + 9'd1;
                end
            end
            rec_next.last = ts_reg;
            if (code_reg == CODE_SEND)
            begin
                if (rec_reg.sent != CNT32_MAX)
                begin
                    rec_next.sent = rec_reg.sent + 32'd1;
                end
                if (rec_reg.pending != PEND_MAX)
                begin
                    if (rec_reg.pending == 16'sd0 && active_reg != CNT9_MAX)
                    begin
                        active_next = active_reg + 9'd1;
                    end
                    rec_next.pending = rec_reg.pending + 16'sd1;
                end
            end
            else if (code_reg == CODE_RECV || code_reg == CODE_DROP)
            begin
                if (code_reg == CODE_DROP && rec_reg.lost != CNT32_MAX)
                begin
                    rec_next.lost = rec_reg.lost + 32'd1;
                end
                if (rec_reg.pending != PEND_MIN)
                begin
                    rec_next.pending = pend_dn;
                    if (pend_dn == 16'sd0 && active_reg != 9'd0)
                    begin
                        active_next = active_reg - 9'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            seen_reg     <= '0;
            active_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_BITS'(1);
                end
            end
            if (cmd.update)
            begin
                fill_reg   <= fill_next;
                seen_reg   <= seen_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg   <= flow_id & ID_MASK;
            code_reg <= command;
            ts_reg   <= timestamp;
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_BITS-1:0];
        end
        if (cmd.take)
        begin
            if (hit)
            begin
                rec_reg   <= rd_rec;
                entry_reg <= cmp_idx_reg;
                fresh_reg <= 1'b0;
                full_reg  <= 1'b0;
            end
            else
            begin
                rec_reg.flow    <= id_reg;
                rec_reg.pending <= 16'sd0;
                rec_reg.sent    <= '0;
                rec_reg.lost    <= '0;
                rec_reg.start   <= ts_reg;
                rec_reg.last    <= ts_reg;
                entry_reg       <= fill_reg[IDX_BITS-1:0];
                fresh_reg       <= has_room;
                full_reg        <= !has_room;
            end
        end
        if (cmd.update)
        begin
            new_flow_reg     <= fresh_reg && !full_reg;
            table_full_reg   <= full_reg;
            flow_total_reg   <= seen_next;
            active_total_reg <= active_next;
            out_rec_reg      <= full_reg ? fet_rec_t'('0) : rec_next;
        end
    end

    assign done         = done_reg;
    assign new_flow     = new_flow_reg;
    assign table_full   = table_full_reg;
    assign flow_total   = flow_total_reg;
    assign active_total = active_total_reg;
    assign in_flight    = out_rec_reg.pending;
    assign sent_count   = out_rec_reg.sent;
    assign lost_count   = out_rec_reg.lost;
    assign first_time   = out_rec_reg.start;
    assign latest_time  = out_rec_reg.last;

endmodule
